/* rtl/i2ctb_pkg.sv */
// ----------------------------------------------------------------------------
// i2ctb_pkg
// Shared types and codes of the byte-level I2C target: bus phases, request
// kinds, register indexes, the buffer request struct and the result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package i2ctb_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 32;
   localparam int MEM_ADDR_W           = 8;   // covers depths up to 256

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ADDR = 2'd1,
      PH_RECV = 2'd2,
      PH_XMIT = 2'd3
   } phase_type;

   localparam logic [2:0] KIND_START      = 3'd0;
   localparam logic [2:0] KIND_STOP       = 3'd1;
   localparam logic [2:0] KIND_BYTE       = 3'd2;
   localparam logic [2:0] KIND_MASTER_ACK = 3'd3;
   localparam logic [2:0] KIND_HOST_WRITE = 3'd4;
   localparam logic [2:0] KIND_HOST_READ  = 3'd5;

   localparam logic [1:0] ACK_NONE = 2'd0;
   localparam logic [1:0] ACK_ACK  = 2'd1;
   localparam logic [1:0] ACK_NACK = 2'd2;

   localparam logic CSR_OWN_ADDRESS = 1'b0;
   localparam logic CSR_LENGTH      = 1'b1;

   localparam logic [7:0] GENERAL_CALL = 8'h00;
   localparam logic [7:0] READ_BIT     = 8'h01;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [MEM_ADDR_W-1:0] addr;
      logic [7:0]            wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [1:0] ack_drive;
      logic       send_valid;
      logic       released;
      logic       host_rd;
      phase_type  bus_phase;
   } result_type;

endpackage

`default_nettype wire

/* rtl/i2ctb_mem.sv */
// ----------------------------------------------------------------------------
// i2ctb_mem
// Shared byte buffer: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctb_mem
   import i2ctb_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output logic [7:0]       rd_data
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   logic [7:0] buffer_mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         buffer_mem[mem_req.addr[AW-1:0]] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= buffer_mem[mem_req.addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/i2ctb_ctrl.sv */
// ----------------------------------------------------------------------------
// i2ctb_ctrl
// Bus phase state machine, byte position counter and configuration
// registers. Decodes one request per cycle into a buffer access and a result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctb_ctrl
   import i2ctb_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [2:0]  kind,
   input  wire logic [7:0]  bus_byte,
   input  wire logic        master_nack,
   input  wire logic [4:0]  host_index,
   input  wire logic [7:0]  host_data,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data,
   output mem_req_type      mem_req,
   output result_type       result
);

   localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

   phase_type   phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   logic [6:0]  own_address_ff;
   logic [5:0]  length_ff;

   logic [8:0]  usable;
   logic        room;
   logic        addr_match;
   logic        host_in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         length_ff      <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_OWN_ADDRESS) begin
            own_address_ff <= csr_data;
         end else begin
            length_ff <= csr_data[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   always_comb begin
      usable        = (9'(length_ff) > DEPTH9) ? DEPTH9 : 9'(length_ff);
      room          = 9'(pos_ff) < usable;
      addr_match    = (bus_byte == GENERAL_CALL) || (bus_byte[7:1] == own_address_ff);
      host_in_range = 9'(host_index) < DEPTH9;
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      unique case (kind)
         KIND_START: begin
            phase_in = PH_ADDR;
            pos_in   = '0;
         end
         KIND_STOP: begin
            phase_in = PH_IDLE;
         end
         KIND_BYTE: begin
            if (phase_ff == PH_ADDR) begin
               if (!addr_match) begin
                  phase_in = PH_IDLE;
               end else if ((bus_byte & READ_BIT) == READ_BIT) begin
                  phase_in = room ? PH_XMIT : PH_IDLE;
                  pos_in   = room ? pos_ff + 6'd1 : pos_ff;
               end else begin
                  phase_in = PH_RECV;
               end
            end else if (phase_ff == PH_RECV && room) begin
               pos_in = pos_ff + 6'd1;
            end
         end
         KIND_MASTER_ACK: begin
            if (phase_ff == PH_XMIT) begin
               if (master_nack || !room) begin
                  phase_in = PH_IDLE;
               end else begin
                  pos_in = pos_ff + 6'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      mem_req           = '0;
      mem_req.addr      = MEM_ADDR_W'(pos_ff);
      mem_req.wr_data   = bus_byte;
      result            = '0;
      result.bus_phase  = phase_in;
      unique case (kind)
         KIND_STOP: begin
            result.released = 1'b1;
         end
         KIND_BYTE: begin
            if (phase_ff == PH_ADDR) begin
               if (!addr_match) begin
                  result.released = 1'b1;
               end else begin
                  result.ack_drive = ACK_ACK;
                  if ((bus_byte & READ_BIT) == READ_BIT) begin
                     result.send_valid = room;
                     result.released   = !room;
                     mem_req.rd_en     = room;
                  end
               end
            end else if (phase_ff == PH_RECV) begin
               result.ack_drive = room ? ACK_ACK : ACK_NACK;
               mem_req.wr_en    = room;
            end
         end
         KIND_MASTER_ACK: begin
            if (phase_ff == PH_XMIT) begin
               result.send_valid = !master_nack && room;
               result.released   = master_nack || !room;
               mem_req.rd_en     = !master_nack && room;
            end
         end
         KIND_HOST_WRITE: begin
            mem_req.addr    = MEM_ADDR_W'(host_index);
            mem_req.wr_data = host_data;
            mem_req.wr_en   = host_in_range;
         end
         KIND_HOST_READ: begin
            mem_req.addr   = MEM_ADDR_W'(host_index);
            mem_req.rd_en  = host_in_range;
            result.host_rd = host_in_range;
         end
         default: begin
         end
      endcase
      // drop the access unless the request is taken this cycle
      mem_req.wr_en = mem_req.wr_en && accept;
      mem_req.rd_en = mem_req.rd_en && accept;
   end

endmodule

`default_nettype wire

/* rtl/i2c_target_byte_fsm.sv */
// ----------------------------------------------------------------------------
// i2c_target_byte_fsm
// Byte-level I2C target with a 7-bit address over a shared byte buffer.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while req_tready is high and gives
// exactly one response: the decode stage decodes the event, updates the
// phase and byte position and issues the buffer access; the read stage then
// picks up the registered buffer read data into the response register.
// The buffer memory has a single port, one read or one write per cycle, and
// each request needs at most one access, so no request waits on another.
// A stalled response register holds one response and one more waits in the
// read stage; then req_tready drops until rsp_tready frees a slot. Buffer
// entries never written read back undefined data. Configuration writes are
// taken in any cycle and must only happen while the block is idle.
`default_nettype none

module i2c_target_byte_fsm
   import i2ctb_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [2:0]  req_tuser,   // kind
   input  wire logic [23:0] req_tdata,   // bus_byte, master_nack, host_index, host_data
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0] rsp_tdata,        // ack_drive, send_valid, send_byte, released,
                                         // host_read_data, bus_phase
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data
);

   logic        accept;
   mem_req_type mem_req;
   result_type  result;
   logic [7:0]  rd_data;

   logic        s1_valid_ff;
   result_type  s1_res_ff;
   logic        out_valid_ff;
   logic [23:0] out_data_ff;
   logic        s1_advance;
   logic        out_free;
   logic [7:0]  send_byte;
   logic [7:0]  host_read_data;

   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   i2ctb_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_tuser),
      .bus_byte    (req_tdata[7:0]),
      .master_nack (req_tdata[8]),
      .host_index  (req_tdata[13:9]),
      .host_data   (req_tdata[21:14]),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mem_req     (mem_req),
      .result      (result)
   );

   i2ctb_mem #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= result;
      end
   end

   assign send_byte      = s1_res_ff.send_valid ? rd_data : 8'h00;
   assign host_read_data = s1_res_ff.host_rd ? rd_data : 8'h00;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_data_ff <= {2'b00, s1_res_ff.bus_phase, host_read_data,
                         s1_res_ff.released, send_byte, s1_res_ff.send_valid,
                         s1_res_ff.ack_drive};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

/* rtl/i2ctb_checker.sv */
// ----------------------------------------------------------------------------
// i2ctb_checker
// Port-level checks of the I2C target response stream.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctb_checker
   import i2ctb_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [2:0]  req_tuser,
   input wire logic [23:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic        csr_index,
   input wire logic [6:0]  csr_data
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // a release always lands in the idle phase
   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> rsp_tdata[21:20] == PH_IDLE)
      else $error("release reported outside idle phase");

   // a sent byte leaves the block waiting for the master's ack
   a_send_xmit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[21:20] == PH_XMIT && !rsp_tdata[11])
      else $error("send without transmit phase");

   // send byte is zero when nothing is sent
   a_send_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[10:3] == 8'h00)
      else $error("send byte set without send valid");

   // a response does not appear out of an idle pipeline without an accepted request
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid || $past(rsp_tvalid, 1) ||
      $past(req_tvalid && req_tready, 2) || $past(rsp_tvalid, 2) ||
      $past(!req_tready, 1))
      else $error("response without request");

endmodule

bind i2c_target_byte_fsm i2ctb_checker u_checker (.*);

`default_nettype wire
